>>> rtl/plks_pkg.sv
// Package for the piecewise linear keyframe sampler.
// Widths, defaults and op codes; no dependencies.
package plks_pkg;
  localparam int unsigned DefMaxKeys = 16;
  localparam int unsigned PosW = 16;
  localparam int unsigned ChanW = 16;
  localparam int unsigned CountW = 5;
  localparam logic OpLoad = 1'b0;
  localparam logic OpSample = 1'b1;
endpackage

>>> rtl/plks_div.sv
// Pipelined restoring divider: quotient of (num << 16) / den, 16 bits.
// One quotient bit per stage; carries a sideband tag. Uses plks_pkg.
module plks_div import plks_pkg::*; #(
  parameter int unsigned TagW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [PosW-1:0] num,
  input  logic [PosW-1:0] den,
  input  logic [TagW-1:0] in_tag,
  output logic            out_valid,
  output logic [PosW-1:0] quo,
  output logic [TagW-1:0] out_tag
);
  logic [PosW:0]   rem [PosW+1];
  logic [PosW-1:0] dv  [PosW+1];
  logic [PosW-1:0] q   [PosW+1];
  logic [TagW-1:0] tg  [PosW+1];
  logic            vl  [PosW+1];

  always_comb begin
    rem[0] = {1'b0, num};
    dv[0] = den;
    q[0] = '0;
    tg[0] = in_tag;
    vl[0] = in_valid;
  end

  for (genvar i = 0; i < PosW; i++) begin : g_stage
    logic [PosW+1:0] sh;
    logic [PosW+1:0] diff;
    always_comb begin
      sh = {rem[i], 1'b0};
      diff = sh - {2'b00, dv[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (adv) begin
        vl[i+1] <= vl[i];
      end
      if (adv) begin
        if (!diff[PosW+1]) begin
          rem[i+1] <= diff[PosW:0];
          q[i+1] <= {q[i][PosW-2:0], 1'b1};
        end else begin
          rem[i+1] <= sh[PosW:0];
          q[i+1] <= {q[i][PosW-2:0], 1'b0};
        end
        dv[i+1] <= dv[i];
        tg[i+1] <= tg[i];
      end
    end
  end

  assign out_valid = vl[PosW];
  assign quo = q[PosW];
  assign out_tag = tg[PosW];
endmodule

>>> rtl/piecewise_linear_keyframe_sample_top.sv
// Top level of the piecewise linear keyframe sampler.
// Uses plks_pkg and plks_div.
// Pipeline of 20 register stages: per-key compare, segment choice with row fetch,
// a 16-stage pipelined divider for the ratio, a registered multiply and the
// output register that takes the final add. One item enters each cycle while
// the output is not stalled; a sample's result is presented by the output
// register after these stages. Loads give no result and update the table at
// once, so a later sample sees them.
module piecewise_linear_keyframe_sample_top import plks_pkg::*; #(
  parameter int unsigned MAX_KEYS = DefMaxKeys
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CountW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [3:0]        entry_index,
  input  logic [PosW-1:0]   key_position,
  input  logic [ChanW-1:0]  key_red,
  input  logic [ChanW-1:0]  key_green,
  input  logic [ChanW-1:0]  key_blue,
  input  logic [PosW-1:0]   sample_position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ChanW-1:0]  out_red,
  output logic [ChanW-1:0]  out_green,
  output logic [ChanW-1:0]  out_blue
);
  localparam int unsigned IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned TagW = 1 + 6 * ChanW;

  logic [CountW-1:0] active_keys;
  logic [PosW-1:0]   keys [MAX_KEYS];
  logic [3*ChanW-1:0] vals [MAX_KEYS];
  logic adv;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_keys <= CountW'(1);
    end else if (cfg_valid) begin
      active_keys <= cfg_data;
    end
  end

  // table held in registers: every key is compared in parallel
  always_ff @(posedge clk) begin
    if (in_valid && adv && op == OpLoad && 32'(entry_index) < MAX_KEYS) begin
      keys[IdxW'(entry_index)] <= key_position;
      vals[IdxW'(entry_index)] <= {key_red, key_green, key_blue};
    end
  end

  // limit index
  logic [IdxW-1:0] limit;
  always_comb begin
    if (active_keys == '0) limit = '0;
    else if (32'(active_keys) > MAX_KEYS) limit = IdxW'(MAX_KEYS - 1);
    else limit = IdxW'(active_keys - CountW'(1));
  end

  // stage 1: per-key compares
  logic            s1_v;
  logic [PosW-1:0] s1_f;
  logic [IdxW-1:0] s1_lim;
  logic [MAX_KEYS-1:0] s1_ge;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= in_valid && op == OpSample;
    if (adv) begin
      s1_f <= sample_position;
      s1_lim <= limit;
      for (int i = 0; i < MAX_KEYS; i++) s1_ge[i] <= sample_position >= keys[i];
    end
  end

  // stage 2: choose segment and fetch rows
  logic [IdxW-1:0] sel;
  logic            found;
  logic            le0, gelim;
  always_comb begin
    le0 = !s1_ge[0] || s1_f == keys[0];
    gelim = s1_ge[s1_lim];
    sel = s1_lim;
    found = 1'b0;
    if (!le0 && !gelim) begin
      for (int n = MAX_KEYS - 2; n >= 0; n--) begin
        if (IdxW'(n) < s1_lim && s1_ge[n] && !s1_ge[n+1]) begin
          sel = IdxW'(n);
          found = 1'b1;
        end
      end
    end
    if (le0) sel = '0;
  end

  logic            s2_v, s2_found;
  logic [PosW-1:0] s2_num, s2_den;
  logic [3*ChanW-1:0] s2_a, s2_b;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
    if (adv) begin
      s2_found <= found;
      s2_num <= s1_f - keys[sel];
      s2_den <= keys[(sel == IdxW'(MAX_KEYS - 1)) ? sel : sel + IdxW'(1)] - keys[sel];
      s2_a <= vals[sel];
      s2_b <= vals[(sel == IdxW'(MAX_KEYS - 1)) ? sel : sel + IdxW'(1)];
    end
  end

  logic            d_v;
  logic [PosW-1:0] ratio;
  logic [TagW-1:0] d_tag;
  plks_div #(.TagW(TagW)) u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s2_v),
    .num(s2_num), .den(s2_den), .in_tag({s2_found, s2_a, s2_b}),
    .out_valid(d_v), .quo(ratio), .out_tag(d_tag)
  );

  // multiply stage
  logic s3_v, s3_found;
  logic [3*ChanW-1:0] s3_a;
  logic signed [ChanW+PosW+1:0] s3_p [3];
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= d_v;
    if (adv) begin
      s3_found <= d_tag[TagW-1];
      s3_a <= d_tag[6*ChanW-1:3*ChanW];
      for (int c = 0; c < 3; c++) begin
        s3_p[c] <= ($signed({1'b0, d_tag[c*ChanW +: ChanW]})
                  - $signed({1'b0, d_tag[3*ChanW + c*ChanW +: ChanW]}))
                  * $signed({1'b0, ratio});
      end
    end
  end

  // add stage into the output register; arithmetic shift gives floor
  logic [ChanW-1:0] res [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res[c] = s3_found
             ? s3_a[c*ChanW +: ChanW] + ChanW'(s3_p[c] >>> PosW)
             : s3_a[c*ChanW +: ChanW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= s3_v;
    if (adv) begin
      out_blue <= res[0];
      out_green <= res[1];
      out_red <= res[2];
    end
  end
endmodule

>>> test/tb.sv
// Testbench for piecewise_linear_keyframe_sample_top: directed table, then random phases.
// Needs plks_pkg and the RTL. Results are checked against a table mirror and segment search.
`timescale 1ns / 1ps

module tb import plks_pkg::*; ();

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_SAMPLE, ROW_CFG} row_kind_t;

  // For ROW_CFG the pos field carries the active key count.
  typedef struct packed {
    row_kind_t   kind;
    logic [3:0]  idx;
    logic [15:0] key;
    rgb_t        val;
    logic [15:0] pos;
    logic        typed;
    rgb_t        want;
  } row_t;

  localparam rgb_t V0 = '{16'h1234, 16'h0000, 16'hFFFF};
  localparam rgb_t V1 = '{16'h2000, 16'hFFFF, 16'h0000};
  localparam rgb_t VF = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
  localparam rgb_t VZ = '{16'h0000, 16'h0000, 16'h0000};
  localparam int NumRows = 18;
  localparam int SettleCycles = 40;

  localparam row_t DirectedRows [NumRows] = '{
    '{ROW_LOAD,   4'd0,  16'h4000, V0, 16'h0000, 1'b0, VZ},
    '{ROW_SAMPLE, 4'd0,  16'h0000, VZ, 16'h0000, 1'b1, V0},
    '{ROW_SAMPLE, 4'd0,  16'h0000, VZ, 16'hFFFF, 1'b1, V0},
    '{ROW_SAMPLE, 4'd0,  16'h0000, VZ, 16'h4000, 1'b1, V0},
    '{ROW_LOAD,   4'd1,  16'h8000, V1, 16'h0000, 1'b0, VZ},
    '{ROW_LOAD,   4'd2,  16'hFFFF, VF, 16'h0000, 1'b0, VZ},
    '{ROW_LOAD,   4'd3,  16'h0000, VZ, 16'h0000, 1'b0, VZ},
    '{ROW_LOAD,   4'd15, 16'hFFFF, VF, 16'h0000, 1'b0, VZ},
    '{ROW_SAMPLE, 4'd0,  16'h0000, VZ, 16'h8000, 1'b1, V0},
    '{ROW_CFG,    4'd0,  16'h0000, VZ, 16'd3,    1'b0, VZ},
    '{ROW_SAMPLE, 4'd0,  16'h0000, VZ, 16'h4000, 1'b1, V0},
    '{ROW_SAMPLE, 4'd0,  16'h0000, VZ, 16'hFFFF, 1'b1, VF},
    '{ROW_SAMPLE, 4'd0,  16'h0000, VZ, 16'h6000, 1'b0, VZ},
    '{ROW_SAMPLE, 4'd0,  16'h0000, VZ, 16'h9000, 1'b0, VZ},
    // last active key is zero: anything above the first key sits at or above it
    '{ROW_CFG,    4'd0,  16'h0000, VZ, 16'd4,    1'b0, VZ},
    '{ROW_SAMPLE, 4'd0,  16'h0000, VZ, 16'h5000, 1'b1, VZ},
    '{ROW_CFG,    4'd0,  16'h0000, VZ, 16'd0,    1'b0, VZ},
    '{ROW_SAMPLE, 4'd0,  16'h0000, VZ, 16'hFFFF, 1'b1, V0}
  };

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CountW-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic              op;
  logic [3:0]        entry_index;
  logic [PosW-1:0]   key_position;
  logic [ChanW-1:0]  key_red;
  logic [ChanW-1:0]  key_green;
  logic [ChanW-1:0]  key_blue;
  logic [PosW-1:0]   sample_position;
  logic              out_valid;
  logic              out_stall;
  logic [ChanW-1:0]  out_red;
  logic [ChanW-1:0]  out_green;
  logic [ChanW-1:0]  out_blue;

  piecewise_linear_keyframe_sample_top uut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_stall, .op, .entry_index, .key_position,
    .key_red, .key_green, .key_blue, .sample_position,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue
  );

  logic [15:0]       key_mirror [16];
  rgb_t              value_mirror [16];
  logic [CountW-1:0] active_setting;
  rgb_t              pending_rgb [$];
  bit                calm;
  int                hold_off;
  int                mismatches;
  int                loads_sent;
  int                samples_sent;
  int                settings_written;
  int                results_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

  function automatic logic [15:0] lerp(logic [15:0] a, logic [15:0] b, int unsigned ratio);
    longint diff;
    longint prod;
    diff = longint'(b) - longint'(a);
    prod = diff * longint'(ratio);
    return 16'(longint'(a) + (prod >>> 16));
  endfunction

  function automatic rgb_t sample_expect(logic [15:0] f);
    int unsigned cnt;
    int unsigned lim;
    int unsigned sel;
    int unsigned width;
    int unsigned ratio;
    bit          found;
    rgb_t        lo;
    rgb_t        hi;
    cnt = (active_setting == 0) ? 1 : (active_setting > 16 ? 16 : active_setting);
    lim = cnt - 1;
    found = 1'b0;
    sel = lim;
    if (f <= key_mirror[0]) begin
      sel = 0;
    end else if (f < key_mirror[lim]) begin
      for (int n = 0; n < lim; n++) begin
        if (!found && f >= key_mirror[n] && f < key_mirror[n+1]) begin
          sel = n;
          found = 1'b1;
        end
      end
    end
    if (!found) return value_mirror[sel];
    width = 32'(key_mirror[sel+1]) - 32'(key_mirror[sel]);
    ratio = ((32'(f) - 32'(key_mirror[sel])) << 16) / width;
    lo = value_mirror[sel];
    hi = value_mirror[sel+1];
    return '{lerp(lo.r, hi.r, ratio), lerp(lo.g, hi.g, ratio), lerp(lo.b, hi.b, ratio)};
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic send(logic o, logic [3:0] idx, logic [15:0] key, rgb_t val,
                      logic [15:0] pos, logic typed, rgb_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    op              <= o;
    entry_index     <= idx;
    key_position    <= key;
    key_red         <= val.r;
    key_green       <= val.g;
    key_blue        <= val.b;
    sample_position <= pos;
    do @(posedge clk); while (in_stall);
    if (o == OpLoad) begin
      key_mirror[idx]   = key;
      value_mirror[idx] = val;
      loads_sent++;
    end else begin
      pending_rgb.push_back(typed ? want : sample_expect(pos));
      samples_sent++;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_active(logic [CountW-1:0] setting);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= setting;
    do @(posedge clk); while (!cfg_ready);
    active_setting = setting;
    settings_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] ascending_key(int idx);
    if ($urandom_range(0, 99) < 15) return 16'($urandom());
    return 16'(idx * 4000 + $urandom_range(0, 3999));
  endfunction

  function automatic logic [15:0] pick_position();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return key_mirror[$urandom_range(0, 15)];
    if (roll < 20) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom());
  endfunction

  function automatic rgb_t random_rgb();
    return '{16'($urandom()), 16'($urandom()), 16'($urandom())};
  endfunction

  // Receiver side: short random stalls, rare long ones, and a forced hold-off.
  initial begin
    int stall_left;
    int roll;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      roll = $urandom_range(0, 99);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (roll < 3) begin
        stall_left = $urandom_range(8, 30);
        out_stall <= 1'b1;
      end else begin
        out_stall <= (roll < 25);
      end
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result %h %h %h", out_red, out_green, out_blue);
      end else begin
        want = pending_rgb.pop_front();
        if (out_red !== want.r || out_green !== want.g || out_blue !== want.b) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch exp %h %h %h got %h %h %h", want.r, want.g, want.b,
                     out_red, out_green, out_blue);
        end
      end
    end
  end

  initial begin
    logic [CountW-1:0] phase_settings [7];
    row_t              row;
    int                mix_len;
    rgb_t              none;
    phase_settings = '{5'd16, 5'd31, 5'd2, 5'd1, 5'd9, 5'd16, 5'd0};
    none = '0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OpLoad;
    entry_index = '0;
    key_position = '0;
    key_red = '0;
    key_green = '0;
    key_blue = '0;
    sample_position = '0;
    active_setting = 5'd1;
    calm = 1'b0;
    hold_off = 0;
    mismatches = 0;
    loads_sent = 0;
    samples_sent = 0;
    settings_written = 0;
    results_seen = 0;
    foreach (key_mirror[i]) begin
      key_mirror[i] = '0;
      value_mirror[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DirectedRows[i]) begin
      row = DirectedRows[i];
      case (row.kind)
        ROW_CFG: write_active(CountW'(row.pos));
        ROW_LOAD: send(OpLoad, row.idx, row.key, row.val, row.pos, 1'b0, none);
        default: send(OpSample, row.idx, row.key, row.val, row.pos, row.typed, row.want);
      endcase
    end

    for (int p = 0; p < 7; p++) begin
      write_active(p == 5 ? CountW'($urandom_range(3, 15)) : phase_settings[p]);
      calm = (p % 3 == 2);
      // fill every slot first so no sample touches an unwritten entry
      for (int i = 0; i < 16; i++)
        send(OpLoad, 4'(i), ascending_key(i), random_rgb(), 16'($urandom()), 1'b0, none);
      if (p == 1) hold_off = 300;
      mix_len = 48;
      for (int k = 0; k < mix_len; k++) begin
        if ($urandom_range(0, 99) < 70) begin
          send(OpSample, 4'($urandom()), 16'($urandom()), random_rgb(), pick_position(),
               1'b0, none);
        end else begin
          int slot;
          slot = $urandom_range(0, 15);
          send(OpLoad, 4'(slot), ascending_key(slot), random_rgb(), 16'($urandom()),
               1'b0, none);
        end
      end
    end

    drain();
    if (pending_rgb.size() != 0) mismatches++;
    $display("tb: %0d loads, %0d samples, %0d results, %0d key-count settings",
             loads_sent, samples_sent, results_seen, settings_written);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
